// ===== hdl/svg_pkg.sv =====
// Package: payload structs, register indexes and CORDIC constants for the sphere vertex generator
`timescale 1ns / 1ps
package svg_pkg;

	localparam int MAX_STACKS_DEF  = 64;
	localparam int MAX_SECTORS_DEF = 128;
	localparam int CORDIC_ITERS    = 20;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_STEP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_STEP = 3'd5;

	localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

	typedef struct packed {
		logic [6:0] stack_index;
		logic [7:0] sector_index;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
	} out_word_t;

	// Two rotators, one for the stack angle and one for the sector angle
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic [1:0]         q;
	} rot_t;

	typedef struct packed {
		rot_t stk;
		rot_t sec;
	} cell_word_t;

	// Arctangent of 2^-i in 1/2^32 turn
	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] t;
		case (i)
			0: t = 34'sd536870912;
			1: t = 34'sd316933406;
			2: t = 34'sd167458907;
			3: t = 34'sd85004756;
			4: t = 34'sd42667331;
			5: t = 34'sd21354465;
			6: t = 34'sd10679838;
			7: t = 34'sd5340245;
			8: t = 34'sd2670163;
			9: t = 34'sd1335087;
			10: t = 34'sd667544;
			11: t = 34'sd333772;
			12: t = 34'sd166886;
			13: t = 34'sd83443;
			14: t = 34'sd41722;
			15: t = 34'sd20861;
			16: t = 34'sd10430;
			17: t = 34'sd5215;
			18: t = 34'sd2608;
			19: t = 34'sd1304;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ===== hdl/svg_cell.sv =====
// One CORDIC rotation cell: advances both rotators by one micro-rotation
`timescale 1ns / 1ps
module svg_cell #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  svg_pkg::cell_word_t d_in,
	output logic                vld_out,
	output svg_pkg::cell_word_t d_out
);
	import svg_pkg::*;

	function automatic rot_t rotate(input rot_t r);
		rot_t o;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		dx = r.y >>> STEP;
		dy = r.x >>> STEP;
		o = r;
		if (!r.z[33]) begin
			o.x = r.x - dx;
			o.y = r.y + dy;
			o.z = r.z - atan_turn(STEP);
		end else begin
			o.x = r.x + dx;
			o.y = r.y - dy;
			o.z = r.z + atan_turn(STEP);
		end
		return o;
	endfunction

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	// Rotate payload
	always_ff @(posedge clk) begin
		if (en) begin
			d_out.stk <= rotate(d_in.stk);
			d_out.sec <= rotate(d_in.sec);
		end
	end

endmodule

// ===== hdl/svg_scale.sv =====
// Output stages: quadrant map, Q1.16 rounding, radius and normal products, centre add
`timescale 1ns / 1ps
module svg_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  svg_pkg::cell_word_t d_in,
	input  logic [23:0]         radius,
	input  logic signed [31:0]  cx,
	input  logic signed [31:0]  cy,
	input  logic signed [31:0]  cz,
	output logic                vld_out,
	output svg_pkg::out_word_t  d_out
);
	import svg_pkg::*;

	function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
		logic signed [33:0] c;
		logic signed [33:0] s;
		c = v;
		if (v > ONE_Q30) c = ONE_Q30;
		if (v < -ONE_Q30) c = -ONE_Q30;
		s = (c + 34'sd8192) >>> 14;
		return s[17:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) r = 32'h7FFFFFFF;
		else if (v < -34'sd2147483648) r = 32'h80000000;
		else r = v[31:0];
		return r;
	endfunction

	logic signed [17:0] cs_s1, ss_s1, cp_s1, sp_s1;
	logic signed [33:0] ccx_s2, ccy_s2;
	logic signed [17:0] ss_s2;
	logic signed [42:0] rz_s2;
	logic signed [58:0] px_s3, py_s3;
	logic signed [33:0] pz_s3;
	logic signed [15:0] nx_s3, ny_s3, nz_s3;
	logic               v_s1, v_s2, v_s3;
	logic signed [33:0] cv_stk, sv_stk, cv_sec, sv_sec;
	logic signed [24:0] rad_s;

	assign rad_s = {1'b0, radius};

	// Map quadrant onto (cos, sin)
	always_comb begin
		unique case (d_in.stk.q)
			2'd0: begin cv_stk = d_in.stk.x;  sv_stk = d_in.stk.y;  end
			2'd1: begin cv_stk = -d_in.stk.y; sv_stk = d_in.stk.x;  end
			2'd2: begin cv_stk = -d_in.stk.x; sv_stk = -d_in.stk.y; end
			default: begin cv_stk = d_in.stk.y; sv_stk = -d_in.stk.x; end
		endcase
		unique case (d_in.sec.q)
			2'd0: begin cv_sec = d_in.sec.x;  sv_sec = d_in.sec.y;  end
			2'd1: begin cv_sec = -d_in.sec.y; sv_sec = d_in.sec.x;  end
			2'd2: begin cv_sec = -d_in.sec.x; sv_sec = -d_in.sec.y; end
			default: begin cv_sec = d_in.sec.y; sv_sec = -d_in.sec.x; end
		endcase
	end

	// Hold valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: round, stage 2: unit products and z radius product, stage 3: radius products and normal
	always_ff @(posedge clk) begin
		if (en) begin
			cs_s1  <= to_q16(cv_stk);
			ss_s1  <= to_q16(sv_stk);
			cp_s1  <= to_q16(cv_sec);
			sp_s1  <= to_q16(sv_sec);
			ccx_s2 <= 34'(cs_s1 * cp_s1);
			ccy_s2 <= 34'(cs_s1 * sp_s1);
			ss_s2  <= ss_s1;
			rz_s2  <= 43'(rad_s * ss_s1);
			px_s3  <= 59'(rad_s * ccx_s2);
			py_s3  <= 59'(rad_s * ccy_s2);
			pz_s3  <= 34'((rz_s2 + 43'sd32768) >>> 16);
			nx_s3  <= 16'((ccx_s2 + 34'sd131072) >>> 18);
			ny_s3  <= 16'((ccy_s2 + 34'sd131072) >>> 18);
			nz_s3  <= 16'((ss_s2 + 18'sd2) >>> 2);
		end
	end

	logic signed [58:0] px_r, py_r;
	assign px_r = (px_s3 + 59'sd2147483648) >>> 32;
	assign py_r = (py_s3 + 59'sd2147483648) >>> 32;

	// Stage 4: add centre and saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out.pos_x  <= sat32(34'(px_r) + 34'(cx));
			d_out.pos_y  <= sat32(34'(py_r) + 34'(cy));
			d_out.pos_z  <= sat32(pz_s3 + 34'(cz));
			d_out.norm_x <= nx_s3;
			d_out.norm_y <= ny_s3;
			d_out.norm_z <= nz_s3;
		end
	end

endmodule

// ===== hdl/sphere_vertex_generator_unit.sv =====
// Top level: sphere vertex generator, CORDIC cell chain plus scaling stages
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_word_t   (stack_index, sector_index)
//  out     | output    | out_valid/out_stall| out_word_t  (pos xyz, norm xyz)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One word per cycle while the output is not stalled; the pipe is 1 angle stage + 20 CORDIC cells + 4 scale stages.
// Most of the depth is the 20-cell rotation chain, one micro-rotation per cell.
// The whole pipe advances when the output register is empty or taken; a stall
// freezes it, and in_stall follows out_stall while the output holds a word.
// Reset clears the valid bits and sets the configuration registers to their defaults.
`timescale 1ns / 1ps
module sphere_vertex_generator_unit #(
	parameter int MAX_STACKS  = svg_pkg::MAX_STACKS_DEF,
	parameter int MAX_SECTORS = svg_pkg::MAX_SECTORS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  svg_pkg::in_word_t                      in_word,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output svg_pkg::out_word_t                     out_word,
	input  logic                                   cfg_we,
	input  logic [svg_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [svg_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import svg_pkg::*;

	logic [23:0]        radius_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [15:0]        stack_step_q, sector_step_q;

	// Write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= 24'd65536;
			cx_q          <= '0;
			cy_q          <= '0;
			cz_q          <= '0;
			stack_step_q  <= 16'd3641;
			sector_step_q <= 16'd3641;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS:      radius_q      <= cfg_data[23:0];
				REG_CENTER_X:    cx_q          <= cfg_data;
				REG_CENTER_Y:    cy_q          <= cfg_data;
				REG_CENTER_Z:    cz_q          <= cfg_data;
				REG_STACK_STEP:  stack_step_q  <= cfg_data[15:0];
				REG_SECTOR_STEP: sector_step_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Clamp indexes and form angles
	logic [15:0] si, sj, a_stk, a_sec;
	always_comb begin
		si = 16'(in_word.stack_index);
		sj = 16'(in_word.sector_index);
		if (si > 16'(MAX_STACKS))  si = 16'(MAX_STACKS);
		if (sj > 16'(MAX_SECTORS)) sj = 16'(MAX_SECTORS);
		a_stk = 16'd16384 - 16'(si * stack_step_q);
		a_sec = 16'(sj * sector_step_q);
	end

	function automatic rot_t seed(input logic [15:0] a);
		rot_t r;
		logic [1:0]  q;
		logic [15:0] res;
		q   = 2'((17'(a) + 17'd8192) >> 14);
		res = a - {q, 14'd0};
		r.x = GAIN_INV;
		r.y = '0;
		r.z = {{2{res[15]}}, res, 16'd0};
		r.q = q;
		return r;
	endfunction

	cell_word_t chain_d [CORDIC_ITERS+1];
	logic       chain_v [CORDIC_ITERS+1];

	// Register seed of both rotators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_v[0] <= 1'b0;
		end else if (en) begin
			chain_v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chain_d[0].stk <= seed(a_stk);
			chain_d[0].sec <= seed(a_sec);
		end
	end

	// Chain of rotation cells
	for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
		svg_cell #(.STEP(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (chain_v[g]),
			.d_in   (chain_d[g]),
			.vld_out(chain_v[g+1]),
			.d_out  (chain_d[g+1])
		);
	end

	svg_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_in (chain_v[CORDIC_ITERS]),
		.d_in   (chain_d[CORDIC_ITERS]),
		.radius (radius_q),
		.cx     (cx_q),
		.cy     (cy_q),
		.cz     (cz_q),
		.vld_out(out_valid),
		.d_out  (out_word)
	);

endmodule

// ===== hdl/svg_checker.sv =====
// Port checker for the sphere vertex generator, bound to the top level
`timescale 1ns / 1ps
module svg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input svg_pkg::out_word_t out_word
);
	import svg_pkg::*;

	// Held word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// Input stalls only behind a stalled output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// The z normal stays on the unit range
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.norm_z <= 16'sd16384 && out_word.norm_z >= -16'sd16384)
		else $error("normal out of range");

	// Free output takes input
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled with free output");

endmodule

bind sphere_vertex_generator_unit svg_checker u_svg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word)
);

// ===== sim/sphere_vertex_generator_unit_tb.sv =====
// Testbench: sphere vertex generator checked word by word against its own CORDIC predictor
`timescale 1ns / 1ps
module sphere_vertex_generator_unit_tb;
	import svg_pkg::*;

	localparam int  PIPE_DEPTH   = 25;
	localparam int  GRID_STACKS  = 64;
	localparam int  GRID_SECTORS = 128;
	localparam int  ROT_STEPS    = 20;
	localparam int  HOLD_CYCLES  = 300;
	localparam int  RAND_PHASES  = 8;
	localparam int  PHASE_WORDS  = 230;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint ROT_GAIN = 64'sd652032874;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam longint ARC_TURN [ROT_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_word_t   in_word = '0;
	logic       out_valid;
	logic       out_stall = 1'b1;
	out_word_t  out_word;
	logic       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register shadow
	logic [23:0]        radius_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [15:0]        stack_step_q, sector_step_q;

	out_word_t vertex_q[$];
	int  errors = 0;
	bit  quiet = 0;
	bit  hold_req = 0;

	typedef struct {
		logic [6:0]         st;
		logic [7:0]         se;
		bit                 pin_x;
		logic signed [31:0] px;
	} row_t;

	sphere_vertex_generator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Cosine and sine of a 16-bit turn angle, Q1.16
	function automatic void turn_sincos(input logic [15:0] ang, output longint c,
			output longint s);
		longint q, r, z, x, y, dx, dy, cv, sv;
		q = ((longint'(ang) + 8192) >> 14) & 3;
		r = longint'(ang) - 16384 * q;
		if (r >= 32768) r -= 65536;
		z = r * 65536;
		x = ROT_GAIN;
		y = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARC_TURN[i];
			end else begin
				x += dx; y -= dy; z += ARC_TURN[i];
			end
		end
		case (q)
			0: begin cv = x;  sv = y;  end
			1: begin cv = -y; sv = x;  end
			2: begin cv = -x; sv = -y; end
			default: begin cv = y; sv = -x; end
		endcase
		if (cv > UNIT_Q30) cv = UNIT_Q30;
		if (cv < -UNIT_Q30) cv = -UNIT_Q30;
		if (sv > UNIT_Q30) sv = UNIT_Q30;
		if (sv < -UNIT_Q30) sv = -UNIT_Q30;
		c = (cv + 8192) >>> 14;
		s = (sv + 8192) >>> 14;
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic out_word_t vertex_of(input in_word_t w);
		out_word_t o;
		int si, sj;
		logic [15:0] stack_ang, sector_ang;
		longint cs, ss, cp, sp, rad;
		si = (w.stack_index > GRID_STACKS) ? GRID_STACKS : int'(w.stack_index);
		sj = (w.sector_index > GRID_SECTORS) ? GRID_SECTORS : int'(w.sector_index);
		stack_ang = 16'(16384 - si * int'(stack_step_q));
		sector_ang = 16'(sj * int'(sector_step_q));
		turn_sincos(stack_ang, cs, ss);
		turn_sincos(sector_ang, cp, sp);
		rad = longint'(radius_q);
		o.pos_x = clip32(((rad * cs * cp + 64'sh80000000) >>> 32) + longint'(cx_q));
		o.pos_y = clip32(((rad * cs * sp + 64'sh80000000) >>> 32) + longint'(cy_q));
		o.pos_z = clip32(((rad * ss + 32768) >>> 16) + longint'(cz_q));
		o.norm_x = 16'((cs * cp + 131072) >>> 18);
		o.norm_y = 16'((cs * sp + 131072) >>> 18);
		o.norm_z = 16'((ss + 2) >>> 2);
		return o;
	endfunction

	// Write one register and track it in the shadow
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RADIUS:      radius_q = d[23:0];
			REG_CENTER_X:    cx_q = d;
			REG_CENTER_Y:    cy_q = d;
			REG_CENTER_Z:    cz_q = d;
			REG_STACK_STEP:  stack_step_q = d[15:0];
			REG_SECTOR_STEP: sector_step_q = d[15:0];
			default: ;
		endcase
	endtask

	// Drop the input, then wait for every expected word
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (vertex_q.size() == 0);
		repeat (PIPE_DEPTH + 5) @(posedge clk);
	endtask

	// Offer one word; a pinned x position overrides the predicted one
	task automatic send(input in_word_t w, input bit pin_x, input logic signed [31:0] px);
		int gap;
		out_word_t e;
		gap = quiet ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		e = vertex_of(w);
		if (pin_x) e.pos_x = px;
		vertex_q = {vertex_q, e};
	endtask

	task automatic send_rand();
		in_word_t w;
		w.stack_index = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
			: 7'($urandom_range(0, GRID_STACKS));
		w.sector_index = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(129, 255))
			: 8'($urandom_range(0, GRID_SECTORS));
		send(w, 0, '0);
	endtask

	task automatic run_rows(input row_t rows[]);
		in_word_t w;
		foreach (rows[i]) begin
			w.stack_index = rows[i].st;
			w.sector_index = rows[i].se;
			send(w, rows[i].pin_x, rows[i].px);
		end
	endtask

	// Receiver: draw a hold per word, then take it
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				n = HOLD_CYCLES;
				hold_req = 0;
			end else begin
				n = quiet ? 0 : $urandom_range(0, 15);
			end
			out_stall <= (n > 0);
			if (n > 0) begin
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each taken word with the oldest expected vertex
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_q.size() == 0) begin
				report("vertex with none expected");
			end else begin
				e = vertex_q.pop_front();
				if (out_word.pos_x !== e.pos_x)
					report($sformatf("pos_x %0d exp %0d", out_word.pos_x, e.pos_x));
				if (out_word.pos_y !== e.pos_y)
					report($sformatf("pos_y %0d exp %0d", out_word.pos_y, e.pos_y));
				if (out_word.pos_z !== e.pos_z)
					report($sformatf("pos_z %0d exp %0d", out_word.pos_z, e.pos_z));
				if (out_word.norm_x !== e.norm_x)
					report($sformatf("norm_x %0d exp %0d", out_word.norm_x, e.norm_x));
				if (out_word.norm_y !== e.norm_y)
					report($sformatf("norm_y %0d exp %0d", out_word.norm_y, e.norm_y));
				if (out_word.norm_z !== e.norm_z)
					report($sformatf("norm_z %0d exp %0d", out_word.norm_z, e.norm_z));
			end
		end
	end

	initial begin
		row_t reset_rows[] = '{
			'{0, 0, 0, 0}, '{64, 0, 0, 0}, '{32, 0, 0, 0}, '{16, 32, 0, 0},
			'{127, 255, 0, 0}, '{65, 129, 0, 0}, '{0, 128, 0, 0}, '{1, 1, 0, 0},
			'{48, 64, 0, 0}, '{100, 200, 0, 0}
		};
		// Equator at sector zero with a huge x offset: x must clip high
		row_t extreme_rows[] = '{
			'{16, 0, 1, 32'sh7FFFFFFF}, '{16, 1, 0, 0}, '{0, 2, 0, 0},
			'{32, 3, 0, 0}, '{64, 128, 0, 0}, '{8, 77, 0, 0}
		};
		row_t flat_rows[] = '{
			'{0, 0, 0, 0}, '{64, 128, 0, 0}, '{33, 17, 0, 0},
			'{127, 255, 0, 0}, '{5, 90, 0, 0}
		};

		radius_q = 24'd65536; cx_q = '0; cy_q = '0; cz_q = '0;
		stack_step_q = 16'd3641; sector_step_q = 16'd3641;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_rows(reset_rows);
		drain();

		cfg_write(REG_RADIUS, 32'd8388608);
		cfg_write(REG_CENTER_X, 32'h7FFFFFFF);
		cfg_write(REG_CENTER_Y, 32'h80000000);
		cfg_write(REG_CENTER_Z, 32'h7FFFFFFF);
		cfg_write(REG_STACK_STEP, 32'hABCD_0400);
		cfg_write(REG_SECTOR_STEP, 32'd32768);
		cfg_write(REG_SPARE_LO, 32'hFFFFFFFF);
		cfg_write(REG_SPARE_HI, 32'h12345678);
		run_rows(extreme_rows);
		drain();

		// Zero radius, zero stack step and sector step of one: unit normal, constant stack angle
		cfg_write(REG_RADIUS, 32'hFF00_0000);
		cfg_write(REG_CENTER_X, 32'h80000000);
		cfg_write(REG_STACK_STEP, 32'd0);
		cfg_write(REG_SECTOR_STEP, 32'd1);
		run_rows(flat_rows);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin
					cfg_write(REG_RADIUS, 32'hFFFFFF);
					cfg_write(REG_STACK_STEP, 32'd1);
					cfg_write(REG_SECTOR_STEP, 32'd0);
				end
				1: begin
					cfg_write(REG_RADIUS, 32'd65536);
					cfg_write(REG_CENTER_X, 32'd0);
					cfg_write(REG_CENTER_Y, 32'd0);
					cfg_write(REG_CENTER_Z, 32'd0);
					cfg_write(REG_STACK_STEP, 32'd512);
					cfg_write(REG_SECTOR_STEP, 32'd512);
				end
				default: begin
					cfg_write(REG_RADIUS, $urandom());
					cfg_write(REG_CENTER_X, $urandom());
					cfg_write(REG_CENTER_Y, $urandom());
					cfg_write(REG_CENTER_Z, $urandom());
					cfg_write(REG_STACK_STEP, ($urandom_range(0, 3) == 0) ? $urandom()
						: $urandom_range(1, 32768));
					cfg_write(REG_SECTOR_STEP, ($urandom_range(0, 3) == 0) ? $urandom()
						: $urandom_range(1, 32768));
				end
			endcase
			quiet = (p == 3);
			if (p == 2) begin
				// Back the pipe up behind a long receiver hold
				hold_req = 1;
				quiet = 1;
				repeat (60) send_rand();
				quiet = 0;
			end
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (p == 4 && k == PHASE_WORDS / 2) begin
					// Pause the sender until every expected word is back
					@(negedge clk);
					in_valid <= 1'b0;
					wait (vertex_q.size() == 0);
				end
				send_rand();
			end
			quiet = 0;
			@(negedge clk);
			in_valid <= 1'b0;
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/svg_pkg.sv
hdl/svg_cell.sv
hdl/svg_scale.sv
hdl/sphere_vertex_generator_unit.sv
hdl/svg_checker.sv
sim/sphere_vertex_generator_unit_tb.sv
